[design/dmd_pkg.sv]
// shared types and constants for the debug message deframer
// no dependencies
package dmd_pkg;

  localparam int KEPT_BYTES_DEF = 3;
  localparam logic [7:0] STOP_BYTE = 8'hA0;
  localparam logic [7:0] LAST_HEADER = 8'hA4;

  typedef enum logic [2:0] {
    KIND_TEXT     = 3'd0,
    KIND_UNEXP    = 3'd1,
    KIND_TEXT_END = 3'd2,
    KIND_NOTE     = 3'd3,
    KIND_CTRL     = 3'd4,
    KIND_OVER     = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_value;
    logic [7:0] first_field;
    logic [7:0] second_field;
    logic [7:0] third_field;
  } result_t;

endpackage

[design/dmd_state.sv]
// message state, length tracking and payload store; decodes one word per cycle while take is high
// depends on dmd_pkg
module dmd_state import dmd_pkg::*; #(
  parameter int KEPT_BYTES = KEPT_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] rx_byte,
  output logic       emit,
  output result_t    res
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_TEXT  = 3'd1,
    ST_NOTE  = 3'd2,
    ST_CTRL  = 3'd3,
    ST_PARAM = 3'd4
  } msg_t;

  msg_t       state_r, state_nxt;
  logic       len_seen_r, len_seen_nxt;
  logic [7:0] decl_len_r, decl_len_nxt;
  logic [7:0] fill_r, fill_nxt;
  logic [7:0] kept_r   [KEPT_BYTES];
  logic [7:0] kept_nxt [KEPT_BYTES];

  always_comb begin
    state_nxt    = state_r;
    len_seen_nxt = len_seen_r;
    decl_len_nxt = decl_len_r;
    fill_nxt     = fill_r;
    kept_nxt     = kept_r;
    emit         = 1'b0;
    res          = '{kind: KIND_UNEXP, byte_value: 8'd0, first_field: 8'd0,
                     second_field: 8'd0, third_field: 8'd0};
    case (state_r)
      ST_TEXT, ST_NOTE, ST_CTRL, ST_PARAM: begin
        if (rx_byte == STOP_BYTE) begin
          state_nxt    = ST_IDLE;
          len_seen_nxt = 1'b0;
          decl_len_nxt = 8'd0;
          fill_nxt     = 8'd0;
          for (int i = 0; i < KEPT_BYTES; i++) kept_nxt[i] = 8'd0;
          case (state_r)
            ST_TEXT: begin
              emit     = 1'b1;
              res.kind = KIND_TEXT_END;
            end
            ST_NOTE, ST_CTRL: begin
              emit             = 1'b1;
              res.kind         = (state_r == ST_NOTE) ? KIND_NOTE : KIND_CTRL;
              res.first_field  = kept_r[0];
              res.second_field = kept_r[1];
              res.third_field  = kept_r[2];
            end
            default: emit = 1'b0;
          endcase
        end else if (state_r == ST_TEXT) begin
          emit           = 1'b1;
          res.kind       = KIND_TEXT;
          res.byte_value = rx_byte;
        end else if (!len_seen_r) begin
          len_seen_nxt = 1'b1;
          decl_len_nxt = rx_byte;
          fill_nxt     = 8'd0;
          for (int i = 0; i < KEPT_BYTES; i++) kept_nxt[i] = 8'd0;
        end else if (fill_r < decl_len_r) begin
          for (int i = 0; i < KEPT_BYTES; i++) begin
            if (fill_r == 8'(i)) kept_nxt[i] = rx_byte;
          end
          fill_nxt = fill_r + 8'd1;
        end else begin
          emit           = 1'b1;
          res.kind       = KIND_OVER;
          res.byte_value = rx_byte;
        end
      end
      default: begin
        if (rx_byte inside {[STOP_BYTE:LAST_HEADER]}) begin
          state_nxt = msg_t'(rx_byte[2:0]);
        end else begin
          state_nxt      = ST_IDLE;
          emit           = 1'b1;
          res.kind       = KIND_UNEXP;
          res.byte_value = rx_byte;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      len_seen_r <= 1'b0;
      decl_len_r <= 8'd0;
      fill_r     <= 8'd0;
      for (int i = 0; i < KEPT_BYTES; i++) kept_r[i] <= 8'd0;
    end else if (take) begin
      state_r    <= state_nxt;
      len_seen_r <= len_seen_nxt;
      decl_len_r <= decl_len_nxt;
      fill_r     <= fill_nxt;
      kept_r     <= kept_nxt;
    end
  end

endmodule

[design/dmd_out_stage.sv]
// result register with valid/ready toward the consumer
// depends on dmd_pkg
module dmd_out_stage import dmd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign room      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) valid_nxt = 1'b1;
    else if (out_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) res_r <= res;
  end

endmodule

[design/debug_message_deframer_core.sv]
// top level of the debug message deframer
// depends on dmd_pkg, dmd_state, dmd_out_stage
//
// One word is taken per cycle unless in_ready is low; each updates the message
// state and, when it causes a result, loads the output register in the same cycle,
// so it appears in the cycle after acceptance. Input is taken whenever the
// output register is empty or being drained, so with out_ready held high the block
// sustains one word per cycle; only the single result register sets that figure.
module debug_message_deframer_core import dmd_pkg::*; #(
  parameter int KEPT_BYTES = KEPT_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_byte_value,
  output logic [7:0] out_first_field,
  output logic [7:0] out_second_field,
  output logic [7:0] out_third_field
);

  logic    take;
  logic    emit;
  logic    room;
  result_t res;
  result_t out_res;

  assign in_ready = room;
  assign take     = in_valid && room;

  dmd_state #(.KEPT_BYTES(KEPT_BYTES)) u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .rx_byte(in_rx_byte),
    .emit   (emit),
    .res    (res)
  );

  dmd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take && emit),
    .res      (res),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_byte_value   = out_res.byte_value;
  assign out_first_field  = out_res.first_field;
  assign out_second_field = out_res.second_field;
  assign out_third_field  = out_res.third_field;

endmodule
